[design/lpd_pkg.sv]
// Package for the length-prefix deframer.
// Holds field widths, status codes and the result struct shared by the parser and the top level.
// No dependencies.
`default_nettype none

package lpd_pkg;

	localparam int unsigned LEN_W     = 31;
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned HDR_BYTES = 4;

	localparam logic [LEN_W-1:0] LEN_RESET = {LEN_W{1'b1}};

	typedef logic [1:0] frame_status_t;

	localparam frame_status_t ST_PAYLOAD = 2'd0;
	localparam frame_status_t ST_EMPTY   = 2'd1;
	localparam frame_status_t ST_INVALID = 2'd2;

	typedef struct packed {
		logic                 valid;
		logic [BYTE_W-1:0]    payload_byte;
		logic                 last_of_packet;
		frame_status_t        frame_status;
	} lpd_result_t;

endpackage

`default_nettype wire

[design/lpd_parser.sv]
// Header and payload tracking for the length-prefix deframer.
// Keeps the frame state and forms the result of one byte; depends on lpd_pkg.
`default_nettype none

module lpd_parser import lpd_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 step,
	input  wire logic [BYTE_W-1:0]    rx_byte,
	input  wire logic [LEN_W-1:0]     max_total_length,
	output lpd_result_t               result
);

	logic [3*BYTE_W-1:0] header_shift_q;
	logic [1:0]          header_bytes_seen_q;
	logic [LEN_W-1:0]    payload_remaining_q;
	logic                in_payload_q;
	logic                halted_q;

	logic [4*BYTE_W-1:0] total;
	logic [LEN_W-1:0]    remaining_dec;
	logic                hdr_done;
	logic                hdr_invalid;
	logic                hdr_empty;

	assign total         = {rx_byte, header_shift_q};
	assign remaining_dec = payload_remaining_q - LEN_W'(1);
	assign hdr_done      = !halted_q && !in_payload_q && (header_bytes_seen_q == 2'(HDR_BYTES - 1));
	assign hdr_invalid   = total[4*BYTE_W-1] || (total[LEN_W-1:0] < LEN_W'(HDR_BYTES))
		|| (total[LEN_W-1:0] > max_total_length);
	assign hdr_empty     = (total[LEN_W-1:0] == LEN_W'(HDR_BYTES));

	always_comb begin
		result = '0;
		if (halted_q) begin
			result = '0;
		end else if (in_payload_q) begin
			result.valid          = 1'b1;
			result.payload_byte   = rx_byte;
			result.last_of_packet = (remaining_dec == '0);
			result.frame_status   = ST_PAYLOAD;
		end else if (hdr_done) begin
			if (hdr_invalid) begin
				result.valid        = 1'b1;
				result.frame_status = ST_INVALID;
			end else if (hdr_empty) begin
				result.valid          = 1'b1;
				result.last_of_packet = 1'b1;
				result.frame_status   = ST_EMPTY;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_shift_q      <= '0;
			header_bytes_seen_q <= '0;
			payload_remaining_q <= '0;
			in_payload_q        <= 1'b0;
			halted_q            <= 1'b0;
		end else if (step && !halted_q) begin
			if (in_payload_q) begin
				payload_remaining_q <= remaining_dec;
				if (remaining_dec == '0) begin
					in_payload_q <= 1'b0;
				end
			end else if (!hdr_done) begin
				unique case (header_bytes_seen_q)
					2'd0: header_shift_q[BYTE_W-1:0]          <= rx_byte;
					2'd1: header_shift_q[2*BYTE_W-1:BYTE_W]   <= rx_byte;
					2'd2: header_shift_q[3*BYTE_W-1:2*BYTE_W] <= rx_byte;
					default: header_shift_q <= header_shift_q;
				endcase
				header_bytes_seen_q <= header_bytes_seen_q + 2'd1;
			end else begin
				header_shift_q      <= '0;
				header_bytes_seen_q <= '0;
				if (hdr_invalid) begin
					halted_q <= 1'b1;
				end else if (!hdr_empty) begin
					payload_remaining_q <= total[LEN_W-1:0] - LEN_W'(HDR_BYTES);
					in_payload_q        <= 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

[design/length_prefix_deframer.sv]
// Top level of the length-prefix deframer: input register, parser, result register.
// Depends on lpd_pkg and lpd_parser.
//
// Channel   Handshake              Payload
// in        in_valid / in_ready    rx_byte
// out       out_valid / out_ready  payload_byte, last_of_packet, frame_status
// cfg       cfg_wr_en              cfg_wr_data (max_total_length)
//
// One byte per cycle unless out stalls; results pass the input and then the result register.
// The parser consumes the input register whenever the result register is empty or drained.
// A stalled output holds the result register and then the input register, then drops in_ready.
// Reset clears the frame state and sets the maximum length to all ones.
`default_nettype none

module length_prefix_deframer import lpd_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wr_en,
	input  wire logic [LEN_W-1:0]     cfg_wr_data,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [BYTE_W-1:0]    rx_byte,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [BYTE_W-1:0]         payload_byte,
	output logic                      last_of_packet,
	output frame_status_t             frame_status
);

	logic [LEN_W-1:0]  max_len_q;
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              valid_s2;
	logic              advance;
	lpd_result_t       result;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= LEN_RESET;
		end else if (cfg_wr_en) begin
			max_len_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	lpd_parser u_parser (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (advance),
		.rx_byte          (byte_s1),
		.max_total_length (max_len_q),
		.result           (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= result.valid;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && result.valid) begin
			payload_byte   <= result.payload_byte;
			last_of_packet <= result.last_of_packet;
			frame_status   <= result.frame_status;
		end
	end

	assign out_valid = valid_s2;

endmodule

`default_nettype wire
